FILE: rtl/core/mcet_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and digit helpers for the elapsed timer display
package mcet_pkg;

	localparam int CHANNELS  = 16;
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FLAG_BITS = 16;
	localparam int SHOWN_W   = 4;
	localparam int CMP_W     = (CH_W > SHOWN_W) ? CH_W : SHOWN_W;
	localparam int SEG_W     = 7;

	localparam logic [5:0] SEC_LAST = 6'd59;
	localparam logic [6:0] MIN_LAST = 7'd99;

	typedef struct packed {
		logic [FLAG_BITS-1:0] run_flags;
		logic [SHOWN_W-1:0]   shown_channel;
		logic                 display_on;
	} mcet_in_t;

	typedef struct packed {
		logic [SEG_W-1:0] seg_minute_tens;
		logic [SEG_W-1:0] seg_minute_ones;
		logic [SEG_W-1:0] seg_second_tens;
		logic [SEG_W-1:0] seg_second_ones;
	} mcet_out_t;

	typedef struct packed {
		logic [5:0] sec;
		logic [6:0] min;
	} mcet_chan_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EMIT
	} mcet_state_t;

	// segment a in bit 0
	function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
		logic [SEG_W-1:0] r;
		unique case (d)
			4'd0: r = 7'h3F;
			4'd1: r = 7'h06;
			4'd2: r = 7'h5B;
			4'd3: r = 7'h4F;
			4'd4: r = 7'h66;
			4'd5: r = 7'h6D;
			4'd6: r = 7'h7D;
			4'd7: r = 7'h07;
			4'd8: r = 7'h7F;
			4'd9: r = 7'h6F;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	// divide by ten through a reciprocal, exact for values up to 127
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] prod;
		prod = 15'(v) * 15'd205;
		return prod[14:11];
	endfunction

	function automatic logic [3:0] ones_of(input logic [6:0] v);
		logic [3:0] t;
		logic [6:0] t10;
		t   = tens_of(v);
		t10 = (7'(t) << 3) + (7'(t) << 1);
		return 4'(v - t10);
	endfunction

endpackage

FILE: rtl/core/mcet_tick.sv
`timescale 1ns / 1ps
// one-second update of a single channel's mm:ss count
module mcet_tick (
	input  logic               run,
	input  mcet_pkg::mcet_chan_t cur,
	output mcet_pkg::mcet_chan_t nxt
);
	import mcet_pkg::*;

	always_comb begin
		nxt = '0;
		if (run) begin
			if (cur.sec >= SEC_LAST) begin
				nxt.sec = '0;
				nxt.min = (cur.min >= MIN_LAST) ? 7'd0 : cur.min + 7'd1;
			end else begin
				nxt.sec = cur.sec + 6'd1;
				nxt.min = cur.min;
			end
		end
	end

endmodule

FILE: rtl/core/mcet_cell.sv
`timescale 1ns / 1ps
// one ring cell holding a channel count, shifted on toward the head
module mcet_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift_en,
	input  mcet_pkg::mcet_chan_t d,
	output mcet_pkg::mcet_chan_t q
);
	import mcet_pkg::*;

	mcet_chan_t cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (shift_en) begin
			cnt_q <= d;
		end
	end

	assign q = cnt_q;

endmodule

FILE: rtl/core/multi_channel_elapsed_timer_display_top.sv
`timescale 1ns / 1ps
// Multi-channel elapsed timer with seven-segment readout. Each transfer on the
// input is one one-second tick; the channel counts live in a ring of CHANNELS
// cells that rotates once per tick, the head entry passing through one update
// unit per cycle. A tick is taken while idle, then the ring rotates through all
// CHANNELS cells, and when the display is enabled the result register is loaded
// once any earlier result has been taken. A finished result waits in its output
// register while the next tick is taken. Reset clears all counts at once; no
// clearing pass is needed.
module multi_channel_elapsed_timer_display_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcet_pkg::mcet_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mcet_pkg::mcet_out_t out_data
);
	import mcet_pkg::*;

	mcet_state_t          state_q, state_nxt;
	logic [CH_W-1:0]      cnt_q;
	logic [FLAG_BITS-1:0] flags_q;
	logic [SHOWN_W-1:0]   shown_q;
	logic                 disp_q;
	mcet_chan_t           sel_q;
	mcet_out_t            out_q;
	logic                 out_valid_q;

	logic       shift_en;
	logic       load_out;
	logic       last;
	logic       match;
	mcet_chan_t ring [CHANNELS];
	mcet_chan_t head_upd;

	assign last  = (cnt_q == CH_W'(CHANNELS - 1));
	assign match = (CMP_W'(cnt_q) == CMP_W'(shown_q));

	// flag bit 0 belongs to the channel now at the head; zeros fill in past the flags
	mcet_tick u_tick (
		.run (flags_q[0]),
		.cur (ring[0]),
		.nxt (head_upd)
	);

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		mcet_chan_t d;
		if (i == CHANNELS - 1) begin : g_tail
			assign d = head_upd;
		end else begin : g_mid
			assign d = ring[i+1];
		end
		mcet_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (d),
			.q        (ring[i])
		);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_SWEEP;
			ST_SWEEP: if (last) state_nxt = disp_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:  if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		in_ready = 1'b0;
		shift_en = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SWEEP: shift_en = 1'b1;
			ST_EMIT:  load_out = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (shift_en) begin
				cnt_q <= last ? '0 : cnt_q + CH_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			flags_q <= in_data.run_flags;
			shown_q <= in_data.shown_channel;
			disp_q  <= in_data.display_on;
			sel_q   <= '0;
		end else if (shift_en) begin
			flags_q <= flags_q >> 1;
			if (match) begin
				sel_q <= head_upd;
			end
		end
		if (load_out) begin
			out_q.seg_minute_tens <= seg_of_digit(tens_of(sel_q.min));
			out_q.seg_minute_ones <= seg_of_digit(ones_of(sel_q.min));
			out_q.seg_second_tens <= seg_of_digit(tens_of(7'(sel_q.sec)));
			out_q.seg_second_ones <= seg_of_digit(ones_of(7'(sel_q.sec)));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_idle_at_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("ring not back at its start while idle");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && last) |=> (state_q != ST_SWEEP))
		else $error("rotation ran past one full turn");

	a_take_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SWEEP && cnt_q == '0))
		else $error("accepted tick did not start a rotation");

	a_emit_only_on_display: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> disp_q)
		else $error("result emitted with display off");

endmodule
